[rtl/planar_exponent_sieve_macros.svh]
// Assertion macros shared by the planar exponent sieve RTL.
// Included by every module that carries concurrent checks.
`ifndef PLANAR_EXPONENT_SIEVE_MACROS_SVH
`define PLANAR_EXPONENT_SIEVE_MACROS_SVH

`ifndef SYNTHESIS
// antecedent implies consequent in the same cycle
`define PES_ASSERT_IMP(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
        else $error("pes assertion failed");
// antecedent implies consequent in the next cycle
`define PES_ASSERT_NXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
        else $error("pes assertion failed");
`else
`define PES_ASSERT_IMP(label, clk, rst_n, ante, cons)
`define PES_ASSERT_NXT(label, clk, rst_n, ante, cons)
`endif

`endif

[rtl/pes_pkg.sv]
// Types, constants and helper functions of the planar exponent sieve.
// No dependencies; used by every other RTL file but the macro header.
package pes_pkg;

    localparam int EXP_W      = 32;               // exponent width
    localparam int PW_W       = 33;               // p^i for p^i <= 2^32
    localparam int NUM_PW     = 9;                // p^0 .. p^8
    localparam int DIVD_W     = 40;               // divider dividend width (p * x)
    localparam int DIVS_W     = 32;               // divider divisor / remainder width
    localparam int DIVC_W     = $clog2(DIVD_W + 1);
    localparam int CFG_IDX_W  = 2;
    localparam int CFG_DATA_W = 8;
    localparam int PRIME_W    = 8;
    localparam int DEGREE_W   = 5;
    localparam int DEG_W      = 4;                // subfield degree counter
    localparam int Q_DEPTH    = 2;                // front-to-back queue depth
    localparam int QPTR_W     = $clog2(Q_DEPTH);
    localparam int QCNT_W     = $clog2(Q_DEPTH + 1);

    localparam logic [CFG_IDX_W-1:0] REG_PRIME  = CFG_IDX_W'(0);
    localparam logic [CFG_IDX_W-1:0] REG_DEGREE = CFG_IDX_W'(1);

    localparam logic [PRIME_W-1:0]  RESET_PRIME  = PRIME_W'(3);
    localparam logic [DEGREE_W-1:0] RESET_DEGREE = DEGREE_W'(5);

    localparam logic [PRIME_W-1:0]  PRIME_THREE  = PRIME_W'(3);
    localparam logic [PRIME_W-1:0]  PRIME_MIN    = PRIME_W'(2);
    localparam logic [DEGREE_W-1:0] DEGREE_BIG   = DEGREE_W'(9);
    localparam logic [PW_W+7:0]     Q_LIMIT      = (PW_W+8)'(64'h1_0000_0000);

    localparam logic [DEG_W-1:0] DEG_FIRST = DEG_W'(2);
    localparam logic [DEG_W-1:0] DEG_END   = DEG_W'(9);

    localparam logic [DIVS_W-1:0] GCD_WANT = DIVS_W'(2);
    localparam logic [DIVS_W-1:0] RES_WANT = DIVS_W'(2);

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_LEAD_RED,
        ST_LEAD_RED_W,
        ST_LEAD_STEP,
        ST_LEAD_STEP_W,
        ST_GCD,
        ST_GCD_W,
        ST_PAR,
        ST_PAR_W,
        ST_DEG,
        ST_DEG_W,
        ST_MATCH,
        ST_DONE
    } t_state;

    typedef struct packed {
        logic [EXP_W-1:0] exponent;
        logic             cfg_err;
    } t_item;

    typedef struct packed {
        logic              start;
        logic [DIVD_W-1:0] dividend;
        logic [DIVS_W-1:0] divisor;
    } t_div_req;

    typedef struct packed {
        logic              busy;
        logic              done;
        logic [DIVS_W-1:0] rem;
    } t_div_rsp;

    typedef struct packed {
        logic                      busy;
        logic                      err;
        logic                      three;
        logic [PRIME_W-1:0]        prime;
        logic [DEGREE_W-1:0]       degree;
        logic [DIVS_W-1:0]         m;
        logic [NUM_PW-1:0]         chk;
        logic [NUM_PW-1:0][PW_W-1:0] pw;
    } t_setup;

    // 3^k, k below 9
    function automatic logic [PW_W:0] pow3(input int k);
        logic [PW_W:0] v;
        v = (PW_W+1)'(1);
        for (int t = 0; t < 8; t++) begin
            if (t < k) begin
                v = v + v + v;
            end
        end
        return v;
    endfunction

    // 2*3^i + 3^(i+1) + ... + 3^(i+len), indices mod d
    function automatic logic [PW_W:0] cyc_val(input int d, input int len, input int i);
        logic [PW_W:0] v;
        int            j;
        v = pow3(i) + pow3(i);
        for (int t = 1; t <= 4; t++) begin
            if (t <= len) begin
                j = i + t;
                if (j >= d) begin
                    j = j - d;
                end
                v = v + pow3(j);
            end
        end
        return v;
    endfunction

endpackage

[rtl/pes_in_if.sv]
// Input channel of the planar exponent sieve: one exponent per beat.
// Depends on pes_pkg for the exponent width.
interface pes_in_if import pes_pkg::*; ();
    logic             valid;
    logic             ready;
    logic [EXP_W-1:0] exponent;

    modport source (output valid, output exponent, input ready);
    modport sink   (input valid, input exponent, output ready);
endinterface

[rtl/pes_out_if.sv]
// Result channel of the planar exponent sieve: four flags per beat.
// Depends on pes_pkg only by convention; no package items used.
interface pes_out_if import pes_pkg::*; ();
    logic valid;
    logic ready;
    logic is_class_leader;
    logic subfield_ok;
    logic passes;
    logic config_error;

    modport source (output valid, output is_class_leader, output subfield_ok,
                    output passes, output config_error, input ready);
    modport sink   (input valid, input is_class_leader, input subfield_ok,
                    input passes, input config_error, output ready);
endinterface

[rtl/planar_exponent_sieve.sv]
// Top level of the planar exponent sieve.
// Depends on pes_pkg, pes_in_if, pes_out_if, pes_setup, pes_front, pes_div, pes_back.
//
// Each exponent beat yields one result beat with four flags. The front end queues up
// to two exponents while the back end works on one. All remainders come from one
// shared 40-step restoring divider. Characteristic three skips the parity remainder,
// a failed gcd, parity or subfield residue test cuts an item short, and items on a
// bad field skip the divider. After reset and after each write to the prime or
// degree register the block forms p^n and accepts no beat meanwhile.
module planar_exponent_sieve import pes_pkg::*; (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_cfg_we,
    input  logic [CFG_IDX_W-1:0]  i_cfg_idx,
    input  logic [CFG_DATA_W-1:0] i_cfg_data,
    pes_in_if.sink                i_in,
    pes_out_if.source             o_out
);

    t_setup   setup;
    t_item    item;
    logic     item_valid;
    logic     pop;
    t_div_req div_req;
    t_div_rsp div_rsp;

    pes_setup u_setup (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_cfg_we   (i_cfg_we),
        .i_cfg_idx  (i_cfg_idx),
        .i_cfg_data (i_cfg_data),
        .o_setup    (setup)
    );

    pes_front u_front (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_in         (i_in),
        .i_setup_busy (setup.busy),
        .i_cfg_err    (setup.err),
        .i_pop        (pop),
        .o_item_valid (item_valid),
        .o_item       (item)
    );

    pes_div u_div (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_req   (div_req),
        .o_rsp   (div_rsp)
    );

    pes_back u_back (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_setup      (setup),
        .i_item_valid (item_valid),
        .i_item       (item),
        .o_pop        (pop),
        .o_div_req    (div_req),
        .i_div_rsp    (div_rsp),
        .o_out        (o_out)
    );

endmodule

[rtl/pes_setup.sv]
// Configuration registers and field setup: q = p^n, m = q-1, p^0..p^8, checks.
// Depends on pes_pkg.
module pes_setup import pes_pkg::*; (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_cfg_we,
    input  logic [CFG_IDX_W-1:0]  i_cfg_idx,
    input  logic [CFG_DATA_W-1:0] i_cfg_data,
    output t_setup                o_setup
);

    logic [PRIME_W-1:0]  r_prime;
    logic [DEGREE_W-1:0] r_degree;
    logic                r_busy;
    logic                r_err;
    logic [DEGREE_W-1:0] r_cnt;
    logic [PW_W-1:0]     r_q;
    logic [PW_W-1:0]     r_pw [1:NUM_PW-1];
    logic [PW_W+7:0]     q_next;
    logic                cfg_hit;
    logic [NUM_PW-1:0]   div_mask;
    logic [NUM_PW-1:0]   chk;
    logic                three;

    assign q_next  = (PW_W+8)'(r_q) * (PW_W+8)'(r_prime);
    assign cfg_hit = i_cfg_we && (i_cfg_idx == REG_PRIME || i_cfg_idx == REG_DEGREE);
    assign three   = (r_prime == PRIME_THREE);

    // registers and power sequencer: one multiply per cycle after a write
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_prime  <= RESET_PRIME;
            r_degree <= RESET_DEGREE;
            r_busy   <= 1'b1;
            r_err    <= 1'b0;
            r_cnt    <= '0;
            r_q      <= PW_W'(1);
        end else if (cfg_hit) begin
            if (i_cfg_idx == REG_PRIME) begin
                r_prime <= i_cfg_data[PRIME_W-1:0];
            end else begin
                r_degree <= i_cfg_data[DEGREE_W-1:0];
            end
            r_busy <= 1'b1;
            r_err  <= 1'b0;
            r_cnt  <= '0;
            r_q    <= PW_W'(1);
        end else if (r_busy) begin
            if (r_prime < PRIME_MIN || r_degree == '0) begin
                r_err  <= 1'b1;
                r_busy <= 1'b0;
            end else if (r_cnt == r_degree) begin
                r_busy <= 1'b0;
            end else if (q_next > Q_LIMIT) begin
                r_err  <= 1'b1;
                r_busy <= 1'b0;
            end else begin
                r_q   <= q_next[PW_W-1:0];
                r_cnt <= r_cnt + 1'b1;
            end
        end
    end

    // keep p^1..p^8 as they come by
    always_ff @(posedge i_clk) begin
        for (int k = 1; k < NUM_PW; k++) begin
            if (r_busy && !cfg_hit && r_cnt == DEGREE_W'(k - 1)) begin
                r_pw[k] <= q_next[PW_W-1:0];
            end
        end
    end

    // subfield degrees that divide n, small compare table
    always_comb begin
        div_mask = '0;
        chk      = '0;
        for (int d = 2; d < NUM_PW; d++) begin
            for (int k = 1; k < 16; k++) begin
                if (d * k < 32 && r_degree == DEGREE_W'(d * k)) begin
                    div_mask[d] = 1'b1;
                end
            end
            chk[d] = div_mask[d] && (d <= 4 || r_degree >= DEGREE_BIG)
                     && (d <= 6 || !three);
        end
    end

    always_comb begin
        o_setup.busy   = r_busy;
        o_setup.err    = r_err;
        o_setup.three  = three;
        o_setup.prime  = r_prime;
        o_setup.degree = r_degree;
        o_setup.m      = DIVS_W'(r_q - PW_W'(1));
        o_setup.chk    = chk;
        o_setup.pw[0]  = PW_W'(1);
        for (int k = 1; k < NUM_PW; k++) begin
            o_setup.pw[k] = r_pw[k];
        end
    end

endmodule

[rtl/pes_front.sv]
// Front end: takes exponent beats, tags them with the field error, queues them.
// Depends on pes_pkg and pes_in_if.
module pes_front import pes_pkg::*; (
    input  logic   i_clk,
    input  logic   i_rst_n,
    pes_in_if.sink i_in,
    input  logic   i_setup_busy,
    input  logic   i_cfg_err,
    input  logic   i_pop,
    output logic   o_item_valid,
    output t_item  o_item
);

    t_item             r_q [Q_DEPTH];
    logic [QPTR_W-1:0] r_wr;
    logic [QPTR_W-1:0] r_rd;
    logic [QCNT_W-1:0] r_cnt;
    logic              push;
    logic              pop;
    t_item             cls;

    // hold off while the field setup is running or the queue is full
    assign i_in.ready   = !i_setup_busy && (r_cnt != QCNT_W'(Q_DEPTH));
    assign push         = i_in.valid && i_in.ready;
    assign pop          = i_pop && (r_cnt != '0);
    assign o_item_valid = (r_cnt != '0);
    assign o_item       = r_q[r_rd];

    // classify: bad field items bypass all arithmetic in the back end
    always_comb begin
        cls.exponent = i_in.exponent;
        cls.cfg_err  = i_cfg_err;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr  <= '0;
            r_rd  <= '0;
            r_cnt <= '0;
        end else begin
            if (push) begin
                r_wr <= (r_wr == QPTR_W'(Q_DEPTH - 1)) ? '0 : r_wr + 1'b1;
            end
            if (pop) begin
                r_rd <= (r_rd == QPTR_W'(Q_DEPTH - 1)) ? '0 : r_rd + 1'b1;
            end
            r_cnt <= r_cnt + QCNT_W'(push) - QCNT_W'(pop);
        end
    end

    always_ff @(posedge i_clk) begin
        if (push) begin
            r_q[r_wr] <= cls;
        end
    end

endmodule

[rtl/pes_div.sv]
// Shared restoring divider: remainder of a 40-bit value by a 32-bit one.
// Depends on pes_pkg. One quotient bit per cycle.
`include "planar_exponent_sieve_macros.svh"
module pes_div import pes_pkg::*; (
    input  logic     i_clk,
    input  logic     i_rst_n,
    input  t_div_req i_req,
    output t_div_rsp o_rsp
);

    logic              r_busy;
    logic              r_done;
    logic [DIVC_W-1:0] r_cnt;
    logic [DIVD_W-1:0] r_num;
    logic [DIVS_W-1:0] r_den;
    logic [DIVS_W-1:0] r_rem;
    logic [DIVS_W:0]   trial;
    logic [DIVS_W:0]   n_rem;

    // shift in one dividend bit, subtract when it fits
    always_comb begin
        trial = {r_rem, r_num[DIVD_W-1]};
        if (trial >= {1'b0, r_den}) begin
            n_rem = trial - {1'b0, r_den};
        end else begin
            n_rem = trial;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_done <= 1'b0;
            if (i_req.start) begin
                r_busy <= 1'b1;
                r_cnt  <= DIVC_W'(DIVD_W);
            end else if (r_busy) begin
                r_cnt <= r_cnt - 1'b1;
                if (r_cnt == DIVC_W'(1)) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_req.start) begin
            r_num <= i_req.dividend;
            r_den <= i_req.divisor;
            r_rem <= '0;
        end else if (r_busy) begin
            r_num <= {r_num[DIVD_W-2:0], 1'b0};
            r_rem <= n_rem[DIVS_W-1:0];
        end
    end

    assign o_rsp.busy = r_busy;
    assign o_rsp.done = r_done;
    assign o_rsp.rem  = r_rem;

    `PES_ASSERT_IMP(a_no_restart, i_clk, i_rst_n, i_req.start, !r_busy)
    `PES_ASSERT_NXT(a_start_busy, i_clk, i_rst_n, i_req.start, r_busy && !r_done)
    `PES_ASSERT_IMP(a_done_idle, i_clk, i_rst_n, r_done, !r_busy)

endmodule

[rtl/pes_back.sv]
// Back end sequencer: class leader test, gcd, parity and subfield residue checks.
// Depends on pes_pkg, pes_out_if; drives the shared divider.
`include "planar_exponent_sieve_macros.svh"
module pes_back import pes_pkg::*; (
    input  logic         i_clk,
    input  logic         i_rst_n,
    input  t_setup       i_setup,
    input  logic         i_item_valid,
    input  t_item        i_item,
    output logic         o_pop,
    output t_div_req     o_div_req,
    input  t_div_rsp     i_div_rsp,
    pes_out_if.source    o_out
);

    t_state              r_state, n_state;
    logic [EXP_W-1:0]    r_exp, n_exp;
    logic                r_err, n_err;
    logic                r_lead, n_lead;
    logic                r_sub, n_sub;
    logic [DIVS_W-1:0]   r_x, n_x;
    logic [DEGREE_W-1:0] r_i, n_i;
    logic [DIVS_W-1:0]   r_a, n_a;
    logic [DIVS_W-1:0]   r_b, n_b;
    logic [DEG_W-1:0]    r_deg, n_deg;
    logic                r_ov, n_ov;
    logic                r_o_lead, r_o_sub, r_o_pass, r_o_err;
    logic                load_out;
    logic                pair_hit;
    logic                cyc_hit;
    logic                div_wait;
    logic                flag_any;

    // residue against p^a + p^b, a <= b < d, all pairs the degree allows in parallel
    always_comb begin
        pair_hit = 1'b0;
        for (int a = 0; a < 8; a++) begin
            for (int b = 0; b < 8; b++) begin
                if (b >= a && DEG_W'(b) < r_deg) begin
                    if (((r_deg == 4'd2 || r_deg == 4'd4 || r_deg == 4'd8) ? (a == b) :
                         (r_deg == 4'd6) ? (((b - a) & 1) == 0) : 1'b1) &&
                        {2'b00, r_x} == ({1'b0, i_setup.pw[a]} + {1'b0, i_setup.pw[b]})) begin
                        pair_hit = 1'b1;
                    end
                end
            end
        end
    end

    // extra cyclic residues, characteristic three only
    always_comb begin
        cyc_hit = 1'b0;
        if (i_setup.three) begin
            for (int i = 0; i < 4; i++) begin
                if (r_deg == 4'd4 && {2'b00, r_x} == cyc_val(4, 2, i)) cyc_hit = 1'b1;
            end
            for (int i = 0; i < 5; i++) begin
                if (r_deg == 4'd5 && {2'b00, r_x} == cyc_val(5, 2, i)) cyc_hit = 1'b1;
            end
            for (int i = 0; i < 6; i++) begin
                if (r_deg == 4'd6 && {2'b00, r_x} == cyc_val(6, 4, i)) cyc_hit = 1'b1;
            end
        end
    end

    // next state and divider requests
    always_comb begin
        n_state   = r_state;
        n_exp     = r_exp;
        n_err     = r_err;
        n_lead    = r_lead;
        n_sub     = r_sub;
        n_x       = r_x;
        n_i       = r_i;
        n_a       = r_a;
        n_b       = r_b;
        n_deg     = r_deg;
        n_ov      = r_ov && !o_out.ready;
        o_pop     = 1'b0;
        o_div_req = '0;
        load_out  = 1'b0;
        unique case (r_state)
            ST_IDLE: begin
                if (i_item_valid) begin
                    o_pop   = 1'b1;
                    n_exp   = i_item.exponent;
                    n_err   = i_item.cfg_err;
                    n_lead  = 1'b1;
                    n_sub   = 1'b1;
                    n_state = i_item.cfg_err ? ST_DONE : ST_LEAD_RED;
                end
            end
            ST_LEAD_RED: begin
                o_div_req.start    = 1'b1;
                o_div_req.dividend = DIVD_W'(r_exp);
                o_div_req.divisor  = i_setup.m;
                n_state            = ST_LEAD_RED_W;
            end
            ST_LEAD_RED_W: begin
                if (i_div_rsp.done) begin
                    n_x     = i_div_rsp.rem;
                    n_i     = DEGREE_W'(1);
                    n_state = ST_LEAD_STEP;
                end
            end
            ST_LEAD_STEP: begin
                if (r_i == i_setup.degree) begin
                    n_a     = r_exp;
                    n_b     = i_setup.m;
                    n_state = ST_GCD;
                end else begin
                    o_div_req.start    = 1'b1;
                    o_div_req.dividend = DIVD_W'(r_x) * DIVD_W'(i_setup.prime);
                    o_div_req.divisor  = i_setup.m;
                    n_state            = ST_LEAD_STEP_W;
                end
            end
            ST_LEAD_STEP_W: begin
                if (i_div_rsp.done) begin
                    n_x = i_div_rsp.rem;
                    if (i_div_rsp.rem < r_exp) begin
                        n_lead  = 1'b0;
                        n_a     = r_exp;
                        n_b     = i_setup.m;
                        n_state = ST_GCD;
                    end else begin
                        n_i     = r_i + 1'b1;
                        n_state = ST_LEAD_STEP;
                    end
                end
            end
            ST_GCD: begin
                if (r_b == '0) begin
                    n_state = ST_PAR;
                end else begin
                    o_div_req.start    = 1'b1;
                    o_div_req.dividend = DIVD_W'(r_a);
                    o_div_req.divisor  = r_b;
                    n_state            = ST_GCD_W;
                end
            end
            ST_GCD_W: begin
                if (i_div_rsp.done) begin
                    n_a     = r_b;
                    n_b     = i_div_rsp.rem;
                    n_state = ST_GCD;
                end
            end
            ST_PAR: begin
                if (r_a != GCD_WANT) begin
                    n_sub   = 1'b0;
                    n_state = ST_DONE;
                end else if (i_setup.three) begin
                    if (r_exp[0]) begin
                        n_sub   = 1'b0;
                        n_state = ST_DONE;
                    end else begin
                        n_deg   = DEG_FIRST;
                        n_state = ST_DEG;
                    end
                end else begin
                    o_div_req.start    = 1'b1;
                    o_div_req.dividend = DIVD_W'(r_exp);
                    o_div_req.divisor  = DIVS_W'(i_setup.prime - 1'b1);
                    n_state            = ST_PAR_W;
                end
            end
            ST_PAR_W: begin
                if (i_div_rsp.done) begin
                    if (i_div_rsp.rem != RES_WANT) begin
                        n_sub   = 1'b0;
                        n_state = ST_DONE;
                    end else begin
                        n_deg   = DEG_FIRST;
                        n_state = ST_DEG;
                    end
                end
            end
            ST_DEG: begin
                if (r_deg == DEG_END) begin
                    n_state = ST_DONE;
                end else if (!i_setup.chk[r_deg]) begin
                    n_deg = r_deg + 1'b1;
                end else begin
                    o_div_req.start    = 1'b1;
                    o_div_req.dividend = DIVD_W'(r_exp);
                    o_div_req.divisor  = DIVS_W'(i_setup.pw[r_deg] - PW_W'(1));
                    n_state            = ST_DEG_W;
                end
            end
            ST_DEG_W: begin
                if (i_div_rsp.done) begin
                    n_x     = i_div_rsp.rem;
                    n_state = ST_MATCH;
                end
            end
            ST_MATCH: begin
                if (pair_hit || cyc_hit) begin
                    n_deg   = r_deg + 1'b1;
                    n_state = ST_DEG;
                end else begin
                    n_sub   = 1'b0;
                    n_state = ST_DONE;
                end
            end
            ST_DONE: begin
                if (!r_ov || o_out.ready) begin
                    load_out = 1'b1;
                    n_ov     = 1'b1;
                    n_state  = ST_IDLE;
                end
            end
            default: begin
                n_state = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_IDLE;
            r_ov    <= 1'b0;
        end else begin
            r_state <= n_state;
            r_ov    <= n_ov;
        end
    end

    always_ff @(posedge i_clk) begin
        r_exp  <= n_exp;
        r_err  <= n_err;
        r_lead <= n_lead;
        r_sub  <= n_sub;
        r_x    <= n_x;
        r_i    <= n_i;
        r_a    <= n_a;
        r_b    <= n_b;
        r_deg  <= n_deg;
        if (load_out) begin
            r_o_lead <= r_lead && !r_err;
            r_o_sub  <= r_sub && !r_err;
            r_o_pass <= r_lead && r_sub && !r_err;
            r_o_err  <= r_err;
        end
    end

    assign o_out.valid           = r_ov;
    assign o_out.is_class_leader = r_o_lead;
    assign o_out.subfield_ok     = r_o_sub;
    assign o_out.passes          = r_o_pass;
    assign o_out.config_error    = r_o_err;

    // states that wait on a divider result
    assign div_wait = r_state == ST_LEAD_RED_W || r_state == ST_LEAD_STEP_W ||
                      r_state == ST_GCD_W || r_state == ST_PAR_W || r_state == ST_DEG_W;
    assign flag_any = r_o_lead || r_o_sub || r_o_pass;

    `PES_ASSERT_IMP(a_err_flags_low, i_clk, i_rst_n, r_ov && r_o_err, !flag_any)
    `PES_ASSERT_IMP(a_pass_and, i_clk, i_rst_n, r_ov, r_o_pass == (r_o_lead && r_o_sub))
    `PES_ASSERT_IMP(a_done_in_wait, i_clk, i_rst_n, i_div_rsp.done, div_wait)
    `PES_ASSERT_NXT(a_pop_leaves_idle, i_clk, i_rst_n, o_pop, r_state != ST_IDLE)

endmodule

[test/planar_exponent_sieve_tb.sv]
// Self-checking testbench for the planar exponent sieve: predicts the four flags of
// every exponent beat and checks the result stream in order.
// Depends on pes_pkg, pes_in_if, pes_out_if and planar_exponent_sieve.
`timescale 1ns / 1ps

module planar_exponent_sieve_tb;
    import pes_pkg::*;

    typedef struct packed {
        logic is_class_leader;
        logic subfield_ok;
        logic passes;
        logic config_error;
    } t_sieve_flags;

    localparam int NUM_SETTINGS = 27;
    localparam int QUIET_FROM   = 24;     // settings from here on run without idling
    localparam int DRAIN_CYCLES = 4000;

    logic                  i_clk;
    logic                  i_rst_n;
    logic                  i_cfg_we;
    logic [CFG_IDX_W-1:0]  i_cfg_idx;
    logic [CFG_DATA_W-1:0] i_cfg_data;

    pes_in_if  in_ch ();
    pes_out_if out_ch ();

    planar_exponent_sieve DUT (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_cfg_we   (i_cfg_we),
        .i_cfg_idx  (i_cfg_idx),
        .i_cfg_data (i_cfg_data),
        .i_in       (in_ch.sink),
        .o_out      (out_ch.source)
    );

    // field settings as the block should hold them
    logic [PRIME_W-1:0]  field_prime;
    logic [DEGREE_W-1:0] field_degree;
    logic [63:0]         pow_tab [9];
    bit                  quiet;

    always begin
        i_clk = 1'b1; #2;
        i_clk = 1'b0; #2;
    end

    // q - 1 of the current field, or 0 when the field is too large or degenerate
    function automatic logic [63:0] field_order_minus1();
        logic [63:0] q;
        q = 64'd1;
        if (field_prime < PRIME_MIN || field_degree == 0) return 64'd0;
        for (int i = 0; i < field_degree; i++) begin
            q = q * field_prime;
            if (q > 64'h1_0000_0000) return 64'd0;
        end
        return q - 64'd1;
    endfunction

    // r == p^a + p^b, a <= b < d, b - a a multiple of step
    function automatic bit pair_sum_hit(logic [63:0] r, int d, int step);
        for (int a = 0; a < d; a++)
            for (int b = a; b < d; b++)
                if (((b - a) % step) == 0 && r == pow_tab[a] + pow_tab[b]) return 1'b1;
        return 1'b0;
    endfunction

    // r == 2p^i + p^(i+1) + ... + p^(i+len), indices mod d
    function automatic bit cyclic_sum_hit(logic [63:0] r, int d, int len);
        logic [63:0] v;
        for (int i = 0; i < d; i++) begin
            v = 2 * pow_tab[i];
            for (int t = 1; t <= len; t++) v = v + pow_tab[(i + t) % d];
            if (r == v) return 1'b1;
        end
        return 1'b0;
    endfunction

    function automatic bit subfield_residue_ok(logic [63:0] e, int d, int step, int len,
                                               bit three);
        logic [63:0] r;
        r = e % (pow_tab[d] - 64'd1);
        if (pair_sum_hit(r, d, step)) return 1'b1;
        return three && len != 0 && cyclic_sum_hit(r, d, len);
    endfunction

    function automatic t_sieve_flags sieve_exponent(logic [EXP_W-1:0] exponent);
        t_sieve_flags f;
        logic [63:0]  e, m, er, pi, a, b, t, p;
        bit           leader, sub, three;
        int           n;
        e = exponent;
        p = field_prime;
        n = field_degree;
        m = field_order_minus1();
        f = '0;
        if (m == 0) begin
            f.config_error = 1'b1;
            return f;
        end
        pow_tab[0] = 64'd1;
        for (int i = 1; i < 9; i++) pow_tab[i] = pow_tab[i-1] * p;
        three = (field_prime == PRIME_THREE);
        // cyclotomic class leader
        leader = 1'b1;
        er = e % m;
        pi = 64'd1;
        for (int i = 1; i < n; i++) begin
            pi = pi * p;
            if ((pi * er) % m < e) begin
                leader = 1'b0;
                break;
            end
        end
        // gcd and parity
        a = e; b = m;
        while (b != 0) begin
            t = a % b; a = b; b = t;
        end
        sub = (a == 64'd2);
        if (sub) sub = three ? (e[0] == 1'b0) : ((e % (p - 64'd1)) == 64'd2);
        // subfield residues
        if (sub && n % 2 == 0) sub = subfield_residue_ok(e, 2, 2, 0, 1'b0);
        if (sub && n % 3 == 0) sub = subfield_residue_ok(e, 3, 1, 0, 1'b0);
        if (sub && n % 4 == 0) sub = subfield_residue_ok(e, 4, 4, 2, three);
        if (sub && n >= 9) begin
            if (n % 5 == 0) sub = subfield_residue_ok(e, 5, 1, 2, three);
            if (sub && n % 6 == 0) sub = subfield_residue_ok(e, 6, 2, 4, three);
            if (sub && !three && n % 7 == 0) sub = subfield_residue_ok(e, 7, 1, 0, 1'b0);
            if (sub && !three && n % 8 == 0) sub = subfield_residue_ok(e, 8, 8, 0, 1'b0);
        end
        f.is_class_leader = leader;
        f.subfield_ok     = sub;
        f.passes          = leader && sub;
        return f;
    endfunction

    // in-order store of predicted flags
    class t_sieve_scoreboard;
        t_sieve_flags pending_flags[$];
        int           errors;

        function void note_exponent(logic [EXP_W-1:0] e);
            pending_flags.push_back(sieve_exponent(e));
        endfunction

        function void check_flags(t_sieve_flags got);
            t_sieve_flags want;
            if (pending_flags.size() == 0) begin
                $error("result beat with no exponent outstanding");
                errors++;
                return;
            end
            want = pending_flags.pop_front();
            if (got.is_class_leader !== want.is_class_leader) begin
                $error("is_class_leader: expected %0b, got %0b",
                       want.is_class_leader, got.is_class_leader);
                errors++;
            end
            if (got.subfield_ok !== want.subfield_ok) begin
                $error("subfield_ok: expected %0b, got %0b", want.subfield_ok, got.subfield_ok);
                errors++;
            end
            if (got.passes !== want.passes) begin
                $error("passes: expected %0b, got %0b", want.passes, got.passes);
                errors++;
            end
            if (got.config_error !== want.config_error) begin
                $error("config_error: expected %0b, got %0b",
                       want.config_error, got.config_error);
                errors++;
            end
        endfunction
    endclass

    t_sieve_scoreboard board;

    // one exponent beat, with an optional idle burst ahead of it
    task automatic send_exponent(logic [EXP_W-1:0] e);
        if (!quiet && $urandom_range(0, 3) == 0) begin
            in_ch.valid <= 1'b0;
            repeat ($urandom_range(1, 19)) @(posedge i_clk);
        end
        in_ch.valid    <= 1'b1;
        in_ch.exponent <= e;
        do @(posedge i_clk); while (!in_ch.ready);
        board.note_exponent(e);
    endtask

    // register write while idle; called on a clock edge, returns on the clock edge after
    // the write enable drops
    task automatic write_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] data);
        i_cfg_we   <= 1'b1;
        i_cfg_idx  <= idx;
        i_cfg_data <= data;
        @(posedge i_clk);
        i_cfg_we   <= 1'b0;
        if (idx == REG_PRIME) field_prime = data;
        else if (idx == REG_DEGREE) field_degree = data[DEGREE_W-1:0];
        @(posedge i_clk);
    endtask

    // random exponent, biased toward values that get past the gcd and parity tests
    function automatic logic [EXP_W-1:0] pick_exponent();
        logic [63:0] m, k;
        int          a, b;
        m = field_order_minus1();
        if (m < 2) return $urandom();
        case ($urandom_range(0, 5))
            0: return $urandom();
            1: return $urandom_range(0, 32'(m));
            2: begin
                a = $urandom_range(0, 8);
                b = $urandom_range(0, 8);
                if (a >= field_degree) a = 0;
                if (b >= field_degree) b = 0;
                return 32'((pow_tab[a] + pow_tab[b]) % m);
            end
            default: begin
                k = (field_prime > 3) ? field_prime - 1 : 2;
                return 32'((k * $urandom_range(0, 32'(m / k)) + 2) % m);
            end
        endcase
    endfunction

    // result side, with random stall bursts
    initial begin
        int stall;
        stall = 0;
        out_ch.ready <= 1'b0;
        forever begin
            @(posedge i_clk);
            if (out_ch.valid && out_ch.ready)
                board.check_flags({out_ch.is_class_leader, out_ch.subfield_ok,
                                   out_ch.passes, out_ch.config_error});
            if (stall == 0 && !quiet && $urandom_range(0, 7) == 0)
                stall = $urandom_range(1, 19);
            out_ch.ready <= (stall == 0);
            if (stall > 0) stall--;
        end
    end

    initial begin
        #40_000_000;
        $display("planar_exponent_sieve_tb: done, errors");
        $finish;
    end

    initial begin
        logic [7:0] primes  [NUM_SETTINGS] = '{3, 3, 3, 3, 3, 3, 3, 3, 5, 7, 251, 251, 2,
                                               2, 2, 2, 0, 1, 4, 11, 5, 13, 3, 3, 5, 3, 2};
        logic [7:0] degrees [NUM_SETTINGS] = '{1, 2, 4, 6, 8, 12, 16, 20, 4, 3, 1, 4, 9,
                                               14, 16, 31, 5, 5, 9, 9, 10, 9, 15, 0, 12,
                                               18, 8};
        logic [EXP_W-1:0] corner [12] = '{0, 1, 2, 3, 4, 20, 241, 242, 243, 32'h8000_0000,
                                          32'hFFFF_FFFE, 32'hFFFF_FFFF};
        board        = new();
        quiet        = 1'b0;
        field_prime  = RESET_PRIME;
        field_degree = RESET_DEGREE;
        i_rst_n        <= 1'b0;
        i_cfg_we       <= 1'b0;
        i_cfg_idx      <= '0;
        i_cfg_data     <= '0;
        in_ch.valid    <= 1'b0;
        in_ch.exponent <= '0;
        repeat (12) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // reset field: corners of the exponent range, then random exponents
        foreach (corner[i]) send_exponent(corner[i]);
        repeat (8) send_exponent(pick_exponent());

        for (int s = 0; s < NUM_SETTINGS; s++) begin
            in_ch.valid <= 1'b0;
            while (board.pending_flags.size() != 0) @(posedge i_clk);
            if (s >= QUIET_FROM) quiet = 1'b1;
            write_reg(REG_PRIME, primes[s]);
            // upper data bits beyond the degree field must be dropped
            write_reg(REG_DEGREE, (s == 1) ? (degrees[s] | 8'hE0) : degrees[s]);
            if (s == 2) write_reg(CFG_IDX_W'(2), 8'hFF);
            if (s == 3) write_reg(CFG_IDX_W'(3), 8'h00);
            send_exponent(32'hFFFF_FFFF);
            send_exponent(32'(field_order_minus1()));
            repeat (9) send_exponent(pick_exponent());
        end

        in_ch.valid <= 1'b0;
        while (board.pending_flags.size() != 0) @(posedge i_clk);
        repeat (DRAIN_CYCLES) @(posedge i_clk);
        if (board.errors == 0 && board.pending_flags.size() == 0) begin
            $display("planar_exponent_sieve_tb: done, clean");
        end else begin
            $display("planar_exponent_sieve_tb: done, errors");
        end
        $finish;
    end
endmodule

[planar_exponent_sieve.f]
+incdir+rtl
rtl/pes_pkg.sv
rtl/pes_in_if.sv
rtl/pes_out_if.sv
rtl/pes_setup.sv
rtl/pes_front.sv
rtl/pes_div.sv
rtl/pes_back.sv
rtl/planar_exponent_sieve.sv
test/planar_exponent_sieve_tb.sv
